// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a property on every rising edge of clk_i while rst_ni is high.
`define P2G_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("p2g assertion failed");
// Checks that the consequent holds whenever the antecedent does.
`define P2G_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("p2g implication failed");
`else
`define P2G_ASSERT(lbl, prop)
`define P2G_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/p2g_pkg.sv =====
`default_nettype none

package p2g_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned DivW    = 2 * PixW;
  localparam int unsigned DivStep = 4;
  localparam int unsigned YuvW    = 20;
  localparam int unsigned LumaW   = 18;

  typedef enum logic [1:0] {
    OpRgb    = 2'd0,
    OpPremul = 2'd1,
    OpYuv    = 2'd2
  } p2g_op_e;

  // Colour triple, index 0 is the first component.
  typedef logic [2:0][PixW-1:0] p2g_rgb_t;

  typedef struct packed {
    logic [DivW-1:0] num;
    logic [PixW-1:0] rem;
    logic [DivW-1:0] quo;
  } p2g_div_lane_t;

  typedef struct packed {
    logic [PixW-1:0]            alpha;
    p2g_div_lane_t [2:0]        lane;
  } p2g_div_t;

  typedef struct packed {
    logic [PixW-1:0]    rem;
    logic [DivStep-1:0] quo;
  } p2g_step_t;

  localparam logic signed [YuvW-1:0] CoefY  = YuvW'(298);
  localparam logic signed [YuvW-1:0] CoefRv = YuvW'(409);
  localparam logic signed [YuvW-1:0] CoefGu = YuvW'(100);
  localparam logic signed [YuvW-1:0] CoefGv = YuvW'(208);
  localparam logic signed [YuvW-1:0] CoefBu = YuvW'(516);
  localparam logic signed [YuvW-1:0] YuvRound = YuvW'(128);

  localparam logic [LumaW-1:0] LumaR     = LumaW'(306);
  localparam logic [LumaW-1:0] LumaG     = LumaW'(601);
  localparam logic [LumaW-1:0] LumaB     = LumaW'(117);
  localparam logic [LumaW-1:0] LumaRound = LumaW'(512);

  // Restoring division, DivStep quotient bits per call.
  function automatic p2g_step_t p2g_div_step(input logic [PixW-1:0]    rem,
                                             input logic [DivStep-1:0] bits,
                                             input logic [PixW-1:0]    divisor);
    logic [PixW:0]      part;
    logic [PixW-1:0]    r;
    logic [DivStep-1:0] q;
    p2g_step_t          res;
    r = rem;
    q = '0;
    for (int i = DivStep - 1; i >= 0; i--) begin
      part = {r, bits[i]};
      if (part >= {1'b0, divisor}) begin
        part = part - {1'b0, divisor};
        q[i] = 1'b1;
      end
      r = part[PixW-1:0];
    end
    res.rem = r;
    res.quo = q;
    return res;
  endfunction

  // Floor of v/256, clamped to 0..255.
  function automatic logic [PixW-1:0] p2g_clamp(input logic signed [YuvW-1:0] v);
    logic [PixW-1:0] res;
    if (v[YuvW-1]) begin
      res = '0;
    end else if (|v[YuvW-2:2*PixW]) begin
      res = '1;
    end else begin
      res = v[2*PixW-1:PixW];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/p2g_if.sv =====
`default_nettype none

interface p2g_pixel_if;
  import p2g_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      operation;
  logic [PixW-1:0] first_component;
  logic [PixW-1:0] second_component;
  logic [PixW-1:0] third_component;
  logic [PixW-1:0] alpha_value;

  modport source (
    output valid, operation, first_component, second_component, third_component,
           alpha_value,
    input  ready
  );
  modport sink (
    input  valid, operation, first_component, second_component, third_component,
           alpha_value,
    output ready
  );
endinterface

interface p2g_gray_if;
  import p2g_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] gray_level;

  modport source (output valid, gray_level, input ready);
  modport sink (input valid, gray_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/p2g_div_stage.sv =====
`default_nettype none

module p2g_div_stage import p2g_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  p2g_div_t div_i,
  output p2g_div_t div_o
);

  p2g_div_t  div_d;
  p2g_div_t  div_q;
  p2g_step_t step [3];

  // Each lane takes the next DivStep dividend bits, most significant first.
  always_comb begin
    div_d.alpha = div_i.alpha;
    for (int l = 0; l < 3; l++) begin
      step[l] = p2g_div_step(div_i.lane[l].rem, div_i.lane[l].num[DivW-1 -: DivStep],
                             div_i.alpha);
      div_d.lane[l].num = {div_i.lane[l].num[DivW-DivStep-1:0], DivStep'(0)};
      div_d.lane[l].rem = step[l].rem;
      div_d.lane[l].quo = {div_i.lane[l].quo[DivW-DivStep-1:0], step[l].quo};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

`default_nettype wire

// ===== rtl/core/pixel_to_gray_converter_core.sv =====
// Channel  Direction  Words carried
// pix_i    in         operation, first/second/third_component, alpha_value
// gray_o   out        gray_level
//
// One word per cycle sustained while gray_o.ready stays high.
// The un-premultiply divider has four stages, four quotient bits a stage.
// Every stage has its own valid bit and moves whenever the stage after it can take
// a word, so bubbles close up under a stall and no word is dropped or repeated.
// Reset clears the valid bits only; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module pixel_to_gray_converter_core import p2g_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  p2g_pixel_if.sink    pix_i,
  p2g_gray_if.source   gray_o
);

  logic [7:1] v_q;
  logic [7:1] en;

  // Stage 1.
  logic signed [PixW+1:0] yc, yd, ye;
  logic [1:0]             op_q1;
  p2g_rgb_t               raw_in, raw_q1;
  logic signed [YuvW-1:0] yb_q1, re_q1, gd_q1, ge_q1, bd_q1;
  p2g_div_t               div_d1, div_q1;
  // Stage 2.
  logic [1:0]             op_q2;
  p2g_rgb_t               raw_q2;
  logic signed [YuvW-1:0] rs_q2, gs_q2, bs_q2;
  // Stages 3 to 5.
  logic [1:0]             op_q3, op_q4, op_q5;
  p2g_rgb_t               rgb_d3, rgb_q3, rgb_q4, rgb_q5;
  p2g_div_t               div_w2, div_w3, div_w4, div_w5;
  // Stage 6.
  p2g_rgb_t               comp;
  logic [LumaW-1:0]       pr_q, pg_q, pb_q;
  // Stage 7.
  logic [LumaW-1:0]       lsum;
  logic [PixW-1:0]        gray_q;

  always_comb begin
    en[7] = !v_q[7] || gray_o.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 7; k >= 2; k--) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (en[1]) begin
        v_q[1] <= pix_i.valid;
      end
    end
  end

  // Stage 1: luma and chroma products and dividends c*255.
  assign raw_in = {pix_i.third_component, pix_i.second_component, pix_i.first_component};
  assign yc = $signed({2'b00, pix_i.first_component}) - 10'sd16;
  assign yd = $signed({2'b00, pix_i.second_component}) - 10'sd128;
  assign ye = $signed({2'b00, pix_i.third_component}) - 10'sd128;

  always_comb begin
    div_d1.alpha = pix_i.alpha_value;
    for (int l = 0; l < 3; l++) begin
      div_d1.lane[l].num = {raw_in[l], PixW'(0)} - DivW'(raw_in[l]);
      div_d1.lane[l].rem = '0;
      div_d1.lane[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op_q1  <= pix_i.operation;
      raw_q1 <= raw_in;
      yb_q1  <= YuvW'(yc) * CoefY + YuvRound;
      re_q1  <= YuvW'(ye) * CoefRv;
      gd_q1  <= YuvW'(yd) * CoefGu;
      ge_q1  <= YuvW'(ye) * CoefGv;
      bd_q1  <= YuvW'(yd) * CoefBu;
      div_q1 <= div_d1;
    end
  end

  // Stage 2: BT.601 sums.
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      op_q2  <= op_q1;
      raw_q2 <= raw_q1;
      rs_q2  <= yb_q1 + re_q1;
      gs_q2  <= yb_q1 - gd_q1 - ge_q1;
      bs_q2  <= yb_q1 + bd_q1;
    end
  end

  p2g_div_stage u_div2 (.clk_i(clk_i), .en_i(en[2]), .div_i(div_q1), .div_o(div_w2));
  p2g_div_stage u_div3 (.clk_i(clk_i), .en_i(en[3]), .div_i(div_w2), .div_o(div_w3));
  p2g_div_stage u_div4 (.clk_i(clk_i), .en_i(en[4]), .div_i(div_w3), .div_o(div_w4));
  p2g_div_stage u_div5 (.clk_i(clk_i), .en_i(en[5]), .div_i(div_w4), .div_o(div_w5));

  // Stage 3: clamp, and pick the colour source for the non-premultiplied modes.
  always_comb begin
    if (op_q2 == OpYuv) begin
      rgb_d3 = {p2g_clamp(bs_q2), p2g_clamp(gs_q2), p2g_clamp(rs_q2)};
    end else begin
      rgb_d3 = raw_q2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      op_q3  <= op_q2;
      rgb_q3 <= rgb_d3;
    end
    if (en[4]) begin
      op_q4  <= op_q3;
      rgb_q4 <= rgb_q3;
    end
    if (en[5]) begin
      op_q5  <= op_q4;
      rgb_q5 <= rgb_q4;
    end
  end

  // Stage 6: in premultiplied mode a zero alpha saturates every component.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (op_q5 != OpPremul) begin
        comp[l] = rgb_q5[l];
      end else if (div_w5.alpha == '0) begin
        comp[l] = '1;
      end else begin
        comp[l] = div_w5.lane[l].quo[PixW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pr_q <= LumaR * LumaW'(comp[0]);
      pg_q <= LumaG * LumaW'(comp[1]);
      pb_q <= LumaB * LumaW'(comp[2]);
    end
  end

  // Stage 7: luma sum into the output register.
  assign lsum = pr_q + pg_q + pb_q + LumaRound;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      gray_q <= lsum[LumaW-1 -: PixW];
    end
  end

  assign gray_o.valid      = v_q[7];
  assign gray_o.gray_level = gray_q;

  `P2G_ASSERT(a_accept_fills, (pix_i.valid && pix_i.ready) |=> v_q[1])
  `P2G_ASSERT(a_stall_holds, (v_q[3] && !en[3]) |=> (v_q[3] && $stable(rgb_q3)))
  `P2G_ASSERT(a_zero_alpha_white, (en[6] && v_q[5] && op_q5 == OpPremul && div_w5.alpha == '0) |=> (lsum[LumaW-1 -: PixW] == '1))

endmodule

`default_nettype wire
